/* rtl/bibpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heart-rate averaging package
// Shared constants and the sequencer state type for the beat interval block.
// ----------------------------------------------------------------------------
package bibpm_pkg;

    // Field widths of the item channels.
    localparam int TIME_W = 32;
    localparam int INST_W = 16;
    localparam int AVG_W  = 8;

    // Beats per minute from a millisecond interval: 60000 / interval.
    localparam int BPM_NUMERATOR = 60000;
    localparam int AVG_MAX       = 255;

    // Default number of beats in the averaging window.
    localparam int DEFAULT_WINDOW = 500;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INST,
        ST_SUM,
        ST_AVG,
        ST_EMIT
    } t_state;

endpackage

/* rtl/bibpm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bibpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 500,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bibpm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module bibpm_div
    import bibpm_pkg::*;
#(
    parameter int DIVIDEND_W = INST_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [TIME_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic [TIME_W-1:0]     r_rem, n_rem;
    logic [TIME_W-1:0]     r_dvs, n_dvs;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [TIME_W:0]       w_shift;
    logic                  w_fit;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_fit   = (w_shift >= {1'b0, r_dvs});
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        if (i_start) begin
            n_cnt = CNT_W'(DIVIDEND_W);
            n_rem = '0;
            n_dvs = i_divisor;
            n_quo = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
            n_rem  = w_fit ? TIME_W'(w_shift - {1'b0, r_dvs}) : w_shift[TIME_W-1:0];
            n_quo  = {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    // Step counter and done flag are reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/beat_interval_bpm_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat interval BPM with moving average
// Turns heartbeat timestamps into instantaneous BPM and a window average.
// ----------------------------------------------------------------------------
// Each accepted item is one beat timestamp in milliseconds. The block takes
// the interval to the previous beat (modulo 2^32, the first beat measured from
// time 0), divides 60000 by it (a zero interval gives 60000), stores the value
// in a ring of WINDOW entries held in a RAM and outputs it with the window sum
// divided by WINDOW, saturated at 255. Entries not yet written count as zero.
// One item is handled at a time: the instantaneous value comes from a
// bit-serial divider that yields one of its INST_W quotient bits per cycle,
// and the average from a multiplication by the reciprocal of WINDOW guarded
// by a saturation compare. After acceptance an item passes the divider and
// then the SUM, AVG and EMIT states before the next acceptance; a result
// still waiting downstream holds the EMIT step. A new item may be accepted
// while the previous result is still waiting downstream. No clearing pass is
// needed after reset: a wrap flag marks when the ring has been filled once.
// ----------------------------------------------------------------------------
module beat_interval_bpm_average
    import bibpm_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat_valid,
    output logic              o_beat_ready,
    input  logic [TIME_W-1:0] i_beat_time_ms,
    output logic              o_result_valid,
    input  logic              i_result_ready,
    output logic [INST_W-1:0] o_instant_bpm,
    output logic [AVG_W-1:0]  o_average_bpm
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(WINDOW * BPM_NUMERATOR + 1);

    // Below (AVG_MAX + 1) * WINDOW the sum fits LO_W bits, and a reciprocal
    // rounded up with this shift gives the exact truncated quotient.
    localparam int SAT_SUM     = (AVG_MAX + 1) * WINDOW;
    localparam int LO_W        = $clog2(SAT_SUM);
    localparam int RECIP_SHIFT = LO_W + $clog2(WINDOW);
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = LO_W + RECIP_W;

    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_wrapped, n_wrapped;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [INST_W-1:0]   r_inst, n_inst;
    logic [AVG_W-1:0]    r_avg, n_avg;
    logic                r_out_valid, n_out_valid;
    logic [INST_W-1:0]   r_out_inst, n_out_inst;
    logic [AVG_W-1:0]    r_out_avg, n_out_avg;

    logic                w_accept;
    logic [TIME_W-1:0]   w_interval;
    logic [INST_W-1:0]   w_old;
    logic [INST_W-1:0]   w_rdata;
    logic                w_ram_we;
    logic                w_div_start;
    logic [INST_W-1:0]   w_div_dividend;
    logic [TIME_W-1:0]   w_div_divisor;
    logic                w_div_done;
    logic [INST_W-1:0]   w_div_quo;
    logic                w_avg_sat;
    logic [PROD_W-1:0]   w_avg_prod;

    assign o_beat_ready = (r_state == ST_IDLE);
    assign w_accept     = i_beat_valid && o_beat_ready;
    assign w_interval   = i_beat_time_ms - r_last;
    assign w_old        = r_wrapped ? w_rdata : '0;

    // Window average: saturation compare and reciprocal multiplication.
    assign w_avg_sat  = (r_sum >= SUM_W'(SAT_SUM));
    assign w_avg_prod = PROD_W'(r_sum[LO_W-1:0]) * PROD_W'(RECIP);

    // Ring of instantaneous values, read at acceptance and written back later.
    bibpm_ram #(
        .WIDTH (INST_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_inst),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // Divider for 60000 / interval.
    bibpm_div #(
        .DIVIDEND_W (INST_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Sequencer: next state, state updates and output register.
    always_comb begin
        n_state        = r_state;
        n_last         = r_last;
        n_slot         = r_slot;
        n_wrapped      = r_wrapped;
        n_sum          = r_sum;
        n_inst         = r_inst;
        n_avg          = r_avg;
        n_out_valid    = r_out_valid && !i_result_ready;
        n_out_inst     = r_out_inst;
        n_out_avg      = r_out_avg;
        w_ram_we       = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = INST_W'(BPM_NUMERATOR);
        w_div_divisor  = (w_interval == '0) ? TIME_W'(1) : w_interval;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_div_start = 1'b1;
                    n_last      = i_beat_time_ms;
                    n_state     = ST_INST;
                end
            end
            ST_INST: begin
                if (w_div_done) begin
                    n_inst  = w_div_quo[INST_W-1:0];
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_sum    = r_sum - SUM_W'(w_old) + SUM_W'(r_inst);
                w_ram_we = 1'b1;
                if (r_slot == SLOT_W'(WINDOW - 1)) begin
                    n_slot    = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
                n_state = ST_AVG;
            end
            ST_AVG: begin
                n_avg   = w_avg_sat ? AVG_W'(AVG_MAX) : w_avg_prod[RECIP_SHIFT +: AVG_W];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_result_ready) begin
                    n_out_valid = 1'b1;
                    n_out_inst  = r_inst;
                    n_out_avg   = r_avg;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and running state are reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= '0;
            r_slot      <= '0;
            r_wrapped   <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_slot      <= n_slot;
            r_wrapped   <= n_wrapped;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_inst     <= n_inst;
        r_avg      <= n_avg;
        r_out_inst <= n_out_inst;
        r_out_avg  <= n_out_avg;
    end

    assign o_result_valid = r_out_valid;
    assign o_instant_bpm  = r_out_inst;
    assign o_average_bpm  = r_out_avg;

endmodule

/* rtl/bibpm_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker for the beat interval block
// Watches the top-level ports and flags behaviour the design must not show.
// ----------------------------------------------------------------------------
module bibpm_chk
    import bibpm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_beat_valid,
    input logic              o_beat_ready,
    input logic [TIME_W-1:0] i_beat_time_ms,
    input logic              o_result_valid,
    input logic              i_result_ready,
    input logic [INST_W-1:0] o_instant_bpm,
    input logic [AVG_W-1:0]  o_average_bpm
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    // A stalled result holds its values.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=>
            o_result_valid && $stable(o_instant_bpm) && $stable(o_average_bpm))
        else $error("stalled result changed");

    // The instantaneous value never exceeds the clamp.
    a_inst_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_instant_bpm <= INST_W'(BPM_NUMERATOR)))
        else $error("instantaneous BPM out of range");

    // One item at a time: the block is busy in the cycle after an item is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_beat_valid && o_beat_ready |=> !o_beat_ready)
        else $error("input ready straight after an accepted item");

endmodule

bind beat_interval_bpm_average bibpm_chk u_bibpm_chk (.*);
